// File: sv/aging_id_table_lru_evict_macros.svh
// Assertion helpers for the aging id table.
`ifndef AGING_ID_TABLE_LRU_EVICT_MACROS_SVH
`define AGING_ID_TABLE_LRU_EVICT_MACROS_SVH

`ifndef ASSERT_OFF
`define AITLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AITLE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define AITLE_ASSERT(lbl, prop, msg)
`define AITLE_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: sv/aitle_pkg.sv
package aitle_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int SLOT_W  = 4;
  localparam int ID_W    = 16;
  localparam int TIME_W  = 32;
  localparam int WORD_W  = 32;
  localparam int LIMIT_W = 31;
  localparam int MC_W    = 5;
  localparam int CMD_W   = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5000);
  localparam logic [MC_W-1:0]    MAX_RESULTS = MC_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT    = 3'd0,
    CMD_GET    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_SNAP   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUT_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] stamp;
    logic [WORD_W-1:0] px;
    logic [WORD_W-1:0] py;
    logic [WORD_W-1:0] pz;
    logic [WORD_W-1:0] rng;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   evicted;
    logic [ID_W-1:0]   entry_id;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] rng;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [2:0]        pad;
    logic [MC_W-1:0]   max_count;
    logic [WORD_W-1:0] voice_range;
    logic [WORD_W-1:0] pos_z;
    logic [WORD_W-1:0] pos_y;
    logic [WORD_W-1:0] pos_x;
    logic [TIME_W-1:0] now_ms;
    logic [ID_W-1:0]   client_id;
  } in_data_t;

  typedef struct packed {
    logic [3:0]        pad;
    logic [WORD_W-1:0] out_range;
    logic [WORD_W-1:0] out_z;
    logic [WORD_W-1:0] out_y;
    logic [WORD_W-1:0] out_x;
    logic [ID_W-1:0]   entry_id;
    logic [ID_W-1:0]   evicted_id;
    logic [SLOT_W-1:0] slot_index;
  } out_data_t;

  typedef struct packed {
    logic              match;
    logic              fresh;
    logic              older;
    logic [TIME_W-1:0] age;
  } eval_t;

  function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] t;
    t = {{SLOT_W{1'b0}}, idx};
    return t[SLOT_W-1:0];
  endfunction

  function automatic res_t miss_res(input logic ok);
    res_t r;
    r      = '0;
    r.ok   = ok;
    r.last = 1'b1;
    return r;
  endfunction

endpackage

// File: sv/aitle_ram.sv
module aitle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/aitle_age_unit.sv
module aitle_age_unit
  import aitle_pkg::*;
(
  input  row_t               row,
  input  logic               valid,
  input  logic [ID_W-1:0]    key,
  input  logic [TIME_W-1:0]  now,
  input  logic [LIMIT_W-1:0] limit,
  input  logic [TIME_W-1:0]  best_age,
  output eval_t              ev
);

  logic [TIME_W-1:0] age;

  assign age      = now - row.stamp;
  assign ev.age   = age;
  assign ev.match = valid && (row.id == key);
  assign ev.fresh = valid && (age <= {1'b0, limit});
  assign ev.older = age > best_age;

endmodule

// File: sv/aging_id_table_lru_evict.sv
// Put, get and remove end their scan early at a match; clear and rejected commands
// skip the scan. A new command is accepted only after the last one has passed its result to the output register.
// One RAM read per cycle, unless a snapshot stall holds the scan, feeds the shared
// age/compare unit. Snapshot results before the last go out during the scan and
// stall it while the output is held.
// Reset clears all valid bits and sets the stale limit to 5000; no clearing pass.
`include "aging_id_table_lru_evict_macros.svh"

module aging_id_table_lru_evict
  import aitle_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [183:0]       s_tdata,  // client_id, now_ms, pos_x, pos_y, pos_z,
                                       // voice_range, max_count, zero pad
  input  logic [CMD_W-1:0]   s_tuser,  // cmd
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [167:0]       m_tdata,  // slot_index, evicted_id, entry_id, out_x,
                                       // out_y, out_z, out_range, zero pad
  output logic               m_tuser,  // ok
  output logic               m_tlast   // last
);

  state_t state, state_next;

  logic [LIMIT_W-1:0] limit;
  logic [ENTRIES-1:0] slot_valid, slot_valid_next;

  cmd_t              cmd_r, cmd_r_next;
  logic [ID_W-1:0]   id_r, id_r_next;
  logic [TIME_W-1:0] now_r, now_r_next;
  logic [WORD_W-1:0] px_r, px_r_next, py_r, py_r_next, pz_r, pz_r_next, rng_r, rng_r_next;
  logic [MC_W-1:0]   maxc_r, maxc_r_next;

  logic [IDX_W:0]    rd_idx, rd_idx_next;
  logic              ev_vld, ev_vld_next;
  logic [IDX_W-1:0]  ev_idx, ev_idx_next;
  logic [MC_W-1:0]   cnt, cnt_next;

  logic              match_found, match_found_next;
  logic [IDX_W-1:0]  match_idx, match_idx_next;
  logic              spare_found, spare_found_next;
  logic [IDX_W-1:0]  spare_idx, spare_idx_next;
  logic [ID_W-1:0]   spare_ev, spare_ev_next;
  logic [IDX_W-1:0]  best_idx, best_idx_next;
  logic [TIME_W-1:0] best_age, best_age_next;
  logic [ID_W-1:0]   best_key, best_key_next;

  res_t res, res_next;
  logic res_vld, res_vld_next;
  res_t out_r, out_r_next;
  logic m_tvalid_next;

  in_data_t  in_d;
  out_data_t out_d;
  cmd_t      in_cmd;
  logic [MC_W-1:0] in_maxc;

  logic            ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  row_t            ram_wrow, row;
  logic [ROW_W-1:0] ram_rdata;

  eval_t ev;
  logic  vld_ev, ev_last, out_free, snap_emit, step, scan_done, reached;
  logic  accept;
  logic [IDX_W-1:0] put_sel;
  logic [ID_W-1:0]  put_ev;
  res_t hit;

  assign in_d     = in_data_t'(s_tdata);
  assign in_cmd   = cmd_t'(s_tuser);
  assign in_maxc  = (in_d.max_count > MAX_RESULTS) ? MAX_RESULTS : in_d.max_count;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign row      = row_t'(ram_rdata);
  assign vld_ev   = slot_valid[ev_idx];
  assign ev_last  = ev_idx == IDX_W'(ENTRIES - 1);
  assign out_free = !m_tvalid || m_tready;
  assign reached  = (cnt + MC_W'(1)) == maxc_r;

  assign snap_emit = (state == ST_SCAN) && ev_vld && (cmd_r == CMD_SNAP) && ev.fresh && res_vld;
  assign step      = !(snap_emit && !out_free);

  assign put_sel = match_found ? match_idx : (spare_found ? spare_idx : best_idx);
  assign put_ev  = match_found ? '0 : (spare_found ? spare_ev : best_key);

  aitle_ram #(
    .WIDTH(ROW_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wrow),
    .re   (ram_re),
    .raddr(rd_idx[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  aitle_age_unit u_age (
    .row     (row),
    .valid   (vld_ev),
    .key     (id_r),
    .now     (now_r),
    .limit   (limit),
    .best_age(best_age),
    .ev      (ev)
  );

  always_comb begin
    hit          = '0;
    hit.ok       = 1'b1;
    hit.slot     = slot_field(ev_idx);
    hit.entry_id = row.id;
    hit.x        = row.px;
    hit.y        = row.py;
    hit.z        = row.pz;
    hit.rng      = row.rng;
    hit.last     = 1'b1;
  end

  always_comb begin
    scan_done = 1'b0;
    if (ev_vld && step) begin
      case (cmd_r)
        CMD_PUT, CMD_GET, CMD_REMOVE: scan_done = ev.match || ev_last;
        CMD_SNAP:                     scan_done = (ev.fresh && reached) || ev_last;
        default:                      scan_done = 1'b1;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_PUT:    state_next = (in_d.client_id == '0) ? ST_RESP : ST_SCAN;
            CMD_GET:    state_next = (in_d.client_id == '0) ? ST_RESP : ST_SCAN;
            CMD_REMOVE: state_next = ST_SCAN;
            CMD_SNAP:   state_next = (in_maxc == '0) ? ST_RESP : ST_SCAN;
            default:    state_next = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = (cmd_r == CMD_PUT) ? ST_PUT_WR : ST_RESP;
        end
      end
      ST_PUT_WR: state_next = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    slot_valid_next  = slot_valid;
    cmd_r_next       = cmd_r;
    id_r_next        = id_r;
    now_r_next       = now_r;
    px_r_next        = px_r;
    py_r_next        = py_r;
    pz_r_next        = pz_r;
    rng_r_next       = rng_r;
    maxc_r_next      = maxc_r;
    rd_idx_next      = rd_idx;
    ev_vld_next      = ev_vld;
    ev_idx_next      = ev_idx;
    cnt_next         = cnt;
    match_found_next = match_found;
    match_idx_next   = match_idx;
    spare_found_next = spare_found;
    spare_idx_next   = spare_idx;
    spare_ev_next    = spare_ev;
    best_idx_next    = best_idx;
    best_age_next    = best_age;
    best_key_next    = best_key;
    res_next         = res;
    res_vld_next     = res_vld;
    out_r_next       = out_r;
    m_tvalid_next    = m_tvalid && !m_tready;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_waddr        = put_sel;
    ram_wrow         = '{id: id_r, stamp: now_r, px: px_r, py: py_r, pz: pz_r, rng: rng_r};

    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd_r_next       = in_cmd;
          id_r_next        = in_d.client_id;
          now_r_next       = in_d.now_ms;
          px_r_next        = in_d.pos_x;
          py_r_next        = in_d.pos_y;
          pz_r_next        = in_d.pos_z;
          rng_r_next       = in_d.voice_range;
          maxc_r_next      = in_maxc;
          rd_idx_next      = '0;
          ev_vld_next      = 1'b0;
          cnt_next         = '0;
          match_found_next = 1'b0;
          spare_found_next = 1'b0;
          res_vld_next     = 1'b0;
          res_next         = miss_res(in_cmd == CMD_CLEAR);
          if (in_cmd == CMD_CLEAR) begin
            slot_valid_next = '0;
          end
        end
      end
      ST_SCAN: begin
        if (step) begin
          if (rd_idx < (IDX_W + 1)'(ENTRIES)) begin
            ram_re      = 1'b1;
            rd_idx_next = rd_idx + (IDX_W + 1)'(1);
            ev_vld_next = 1'b1;
            ev_idx_next = rd_idx[IDX_W-1:0];
          end else begin
            ev_vld_next = 1'b0;
          end
          if (ev_vld) begin
            case (cmd_r)
              CMD_PUT: begin
                if (ev.match) begin
                  match_found_next = 1'b1;
                  match_idx_next   = ev_idx;
                end else begin
                  if (!spare_found && !ev.fresh) begin
                    spare_found_next = 1'b1;
                    spare_idx_next   = ev_idx;
                    spare_ev_next    = vld_ev ? row.id : '0;
                  end
                  if (ev_idx == '0 || ev.older) begin
                    best_idx_next = ev_idx;
                    best_age_next = ev.age;
                    best_key_next = row.id;
                  end
                end
              end
              CMD_GET: begin
                if (ev.match) begin
                  if (ev.fresh) begin
                    res_next = hit;
                  end else begin
                    slot_valid_next[ev_idx] = 1'b0;
                  end
                end
              end
              CMD_REMOVE: begin
                if (ev.match) begin
                  slot_valid_next[ev_idx] = 1'b0;
                  res_next                = hit;
                end
              end
              CMD_SNAP: begin
                if (vld_ev && !ev.fresh) begin
                  slot_valid_next[ev_idx] = 1'b0;
                end
                if (ev.fresh) begin
                  if (res_vld) begin
                    out_r_next    = res;
                    m_tvalid_next = 1'b1;
                  end
                  cnt_next      = cnt + MC_W'(1);
                  res_vld_next  = 1'b1;
                  res_next      = hit;
                  res_next.last = reached || ev_last;
                end else if (ev_last && res_vld) begin
                  res_next.last = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_PUT_WR: begin
        ram_we                   = 1'b1;
        slot_valid_next[put_sel] = 1'b1;
        res_next                 = '{ok: 1'b1, slot: slot_field(put_sel), evicted: put_ev,
                                     entry_id: id_r, x: px_r, y: py_r, z: pz_r, rng: rng_r,
                                     last: 1'b1};
      end
      ST_RESP: begin
        if (out_free) begin
          out_r_next    = res;
          m_tvalid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      limit       <= LIMIT_RESET;
      slot_valid  <= '0;
      cmd_r       <= CMD_PUT;
      maxc_r      <= '0;
      rd_idx      <= '0;
      ev_vld      <= 1'b0;
      ev_idx      <= '0;
      cnt         <= '0;
      match_found <= 1'b0;
      spare_found <= 1'b0;
      res_vld     <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      slot_valid  <= slot_valid_next;
      cmd_r       <= cmd_r_next;
      maxc_r      <= maxc_r_next;
      rd_idx      <= rd_idx_next;
      ev_vld      <= ev_vld_next;
      ev_idx      <= ev_idx_next;
      cnt         <= cnt_next;
      match_found <= match_found_next;
      spare_found <= spare_found_next;
      res_vld     <= res_vld_next;
      m_tvalid    <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    id_r      <= id_r_next;
    now_r     <= now_r_next;
    px_r      <= px_r_next;
    py_r      <= py_r_next;
    pz_r      <= pz_r_next;
    rng_r     <= rng_r_next;
    match_idx <= match_idx_next;
    spare_idx <= spare_idx_next;
    spare_ev  <= spare_ev_next;
    best_idx  <= best_idx_next;
    best_age  <= best_age_next;
    best_key  <= best_key_next;
    res       <= res_next;
    out_r     <= out_r_next;
  end

  always_comb begin
    out_d            = '0;
    out_d.slot_index = out_r.slot;
    out_d.evicted_id = out_r.evicted;
    out_d.entry_id   = out_r.entry_id;
    out_d.out_x      = out_r.x;
    out_d.out_y      = out_r.y;
    out_d.out_z      = out_r.z;
    out_d.out_range  = out_r.rng;
  end

  assign m_tdata = out_d;
  assign m_tuser = out_r.ok;
  assign m_tlast = out_r.last;

  `AITLE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken while busy")
  `AITLE_ASSERT(a_mid_only_snap, m_tvalid && !m_tlast |-> cmd_r == CMD_SNAP, "non-final result outside snapshot")
  `AITLE_ASSERT(a_cnt_bound, cnt <= maxc_r, "snapshot count past limit")
  `AITLE_ASSERT_NEXT(a_stall_hold, state == ST_SCAN && !step, $stable(ev_idx) && $stable(rd_idx), "scan moved while stalled")

endmodule

// File: bench/tb_aging_id_table_lru_evict.sv
module tb_aging_id_table_lru_evict;
  import aitle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = ENTRIES + 8;

  typedef struct {
    bit        ok;
    bit [3:0]  slot;
    bit [15:0] evicted;
    bit [15:0] entry;
    bit [31:0] x;
    bit [31:0] y;
    bit [31:0] z;
    bit [31:0] rng;
    bit        is_last;
  } table_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [183:0]         s_tdata = '0;
  logic [CMD_W-1:0]     s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [167:0]         m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;

  // table image
  bit                   tbl_valid [ENTRIES];
  bit [15:0]            tbl_id    [ENTRIES];
  bit [31:0]            tbl_stamp [ENTRIES];
  bit [31:0]            tbl_px    [ENTRIES];
  bit [31:0]            tbl_py    [ENTRIES];
  bit [31:0]            tbl_pz    [ENTRIES];
  bit [31:0]            tbl_rng   [ENTRIES];
  bit [LIMIT_W-1:0]     age_limit = LIMIT_RESET;

  table_result_t        pending_results [$];
  bit [31:0]            clock_ms;
  bit                   idle_en = 1'b1;
  bit                   offering = 1'b0;
  bit                   hold_off = 1'b0;
  int                   errors = 0;
  int                   n_items [8];
  int                   n_results = 0;
  int                   n_evictions = 0;
  int                   n_multi_snaps = 0;

  aging_id_table_lru_evict dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      flag_error($sformatf("result %0d %s: got %h, expected %h", n_results, name, got, want));
    end
  endtask

  function automatic bit is_fresh(int i, bit [31:0] now);
    bit [31:0] age;
    age = now - tbl_stamp[i];
    return tbl_valid[i] && (age <= {1'b0, age_limit});
  endfunction

  function automatic void push_miss(bit ok);
    table_result_t r;
    r = '{default: 0};
    r.ok = ok;
    r.is_last = 1'b1;
    pending_results.push_back(r);
  endfunction

  function automatic void push_slot(int i, bit [15:0] ev, bit [15:0] id, bit is_last);
    table_result_t r;
    r.ok = 1'b1;
    r.slot = i[3:0];
    r.evicted = ev;
    r.entry = id;
    r.x = tbl_px[i];
    r.y = tbl_py[i];
    r.z = tbl_pz[i];
    r.rng = tbl_rng[i];
    r.is_last = is_last;
    pending_results.push_back(r);
  endfunction

  function automatic void table_predict(bit [2:0] op, bit [15:0] id, bit [31:0] now,
      bit [31:0] px, bit [31:0] py, bit [31:0] pz, bit [31:0] rng, bit [4:0] mc);
    int        i;
    int        hit;
    int        spare;
    int        s;
    int        emitted;
    int        lim;
    bit [31:0] best;
    bit [15:0] ev;
    hit = -1;
    spare = -1;
    emitted = 0;
    ev = '0;
    case (op)
      CMD_PUT: begin
        if (id == 0) begin
          push_miss(1'b0);
          return;
        end
        for (i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i] && tbl_id[i] == id) begin
            hit = i;
            break;
          end
          if (spare < 0 && !is_fresh(i, now)) spare = i;
        end
        s = (hit >= 0) ? hit : spare;
        if (s < 0) begin
          // every slot fresh: oldest goes, ties to the lowest slot
          s = 0;
          best = now - tbl_stamp[0];
          for (i = 1; i < ENTRIES; i++) begin
            if (now - tbl_stamp[i] > best) begin
              best = now - tbl_stamp[i];
              s = i;
            end
          end
        end
        if (tbl_valid[s] && tbl_id[s] != id) begin
          ev = tbl_id[s];
          n_evictions++;
        end
        tbl_id[s] = id;
        tbl_stamp[s] = now;
        tbl_px[s] = px;
        tbl_py[s] = py;
        tbl_pz[s] = pz;
        tbl_rng[s] = rng;
        tbl_valid[s] = 1'b1;
        push_slot(s, ev, id, 1'b1);
      end
      CMD_GET: begin
        if (id != 0) begin
          for (i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_id[i] == id) begin
              if (is_fresh(i, now)) begin
                push_slot(i, 16'd0, id, 1'b1);
                return;
              end
              tbl_valid[i] = 1'b0;
              break;
            end
          end
        end
        push_miss(1'b0);
      end
      CMD_REMOVE: begin
        for (i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i] && tbl_id[i] == id) begin
            tbl_valid[i] = 1'b0;
            push_slot(i, 16'd0, id, 1'b1);
            return;
          end
        end
        push_miss(1'b0);
      end
      CMD_CLEAR: begin
        for (i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
        push_miss(1'b1);
      end
      CMD_SNAP: begin
        lim = (mc > MAX_RESULTS) ? int'(MAX_RESULTS) : int'(mc);
        for (i = 0; i < ENTRIES && emitted < lim; i++) begin
          if (!tbl_valid[i]) continue;
          if (!is_fresh(i, now)) begin
            tbl_valid[i] = 1'b0;
            continue;
          end
          push_slot(i, 16'd0, tbl_id[i], 1'b0);
          emitted++;
        end
        if (emitted == 0) push_miss(1'b0);
        else pending_results[pending_results.size()-1].is_last = 1'b1;
        if (emitted > 1) n_multi_snaps++;
      end
      default: push_miss(1'b0);
    endcase
  endfunction

  task automatic send_command(bit [2:0] op, bit [15:0] id, bit [31:0] now,
      bit [31:0] px, bit [31:0] py, bit [31:0] pz, bit [31:0] rng, bit [4:0] mc);
    in_data_t d;
    if (idle_en && $urandom_range(0, 2) == 0) begin
      if (offering) s_tvalid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    d = '0;
    d.client_id = id;
    d.now_ms = now;
    d.pos_x = px;
    d.pos_y = py;
    d.pos_z = pz;
    d.voice_range = rng;
    d.max_count = mc;
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= op;
    offering = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    table_predict(op, id, now, px, py, pz, rng, mc);
    n_items[op]++;
  endtask

  task automatic wait_idle();
    if (offering) s_tvalid <= 1'b0;
    offering = 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_limit(bit [LIMIT_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    age_limit = value;
  endtask

  function automatic bit [15:0] pick_id();
    case ($urandom_range(0, 19))
      0:       return 16'd0;
      1:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 20));
    endcase
  endfunction

  function automatic bit [31:0] time_step();
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'd0;
      8:       return {1'b0, age_limit};
      9:       return {1'b0, age_limit} + 32'd1;
      default: return $urandom_range(0, age_limit / 8);
    endcase
  endfunction

  task automatic run_random(int count);
    int        k;
    int        sel;
    bit [2:0]  op;
    bit [31:0] now;
    bit [4:0]  mc;
    for (k = 0; k < count; k++) begin
      clock_ms += time_step();
      now = clock_ms;
      sel = $urandom_range(0, 99);
      mc = 5'($urandom_range(0, 31));
      if (sel < 40) op = CMD_PUT;
      else if (sel < 65) op = CMD_GET;
      else if (sel < 75) op = CMD_REMOVE;
      else if (sel < 87) begin
        op = CMD_SNAP;
        if ($urandom_range(0, 3) != 0) mc = 5'($urandom_range(1, 16));
      end else if (sel < 90) op = CMD_CLEAR;
      else begin
        op = 3'($urandom_range(0, 7));
        now = $urandom;
      end
      send_command(op, pick_id(), now, $urandom, $urandom, $urandom, $urandom, mc);
    end
  endtask

  task automatic test_rejects();
    send_command(CMD_PUT, 16'd0, clock_ms, $urandom, $urandom, $urandom, $urandom, 5'd0);
    send_command(CMD_GET, 16'd0, clock_ms, '0, '0, '0, '0, 5'd0);
    send_command(3'd5, 16'd1, clock_ms, '0, '0, '0, '0, 5'd16);
    send_command(3'd7, 16'hFFFF, clock_ms, '1, '1, '1, '1, 5'd31);
    send_command(CMD_SNAP, 16'd0, clock_ms, '0, '0, '0, '0, 5'd0);
  endtask

  task automatic test_fill_and_evict();
    bit [31:0] t0;
    int        i;
    t0 = clock_ms;
    for (i = 0; i < ENTRIES; i++) begin
      if (i == 0) send_command(CMD_PUT, 16'hFFFF, t0, '1, '1, '1, '1, 5'd0);
      else if (i == 1) send_command(CMD_PUT, 16'd1, t0, '0, '0, '0, '0, 5'd31);
      else send_command(CMD_PUT, 16'(i), t0 + i, $urandom, $urandom, $urandom, $urandom,
                        5'd0);
    end
    // slots 0 and 1 tie as oldest, slot 0 must go
    send_command(CMD_PUT, 16'h8000, t0 + 20, $urandom, $urandom, $urandom, $urandom, 5'd0);
    send_command(CMD_SNAP, 16'd0, t0 + 21, '0, '0, '0, '0, 5'd31);
    clock_ms = t0 + 21;
  endtask

  task automatic test_lookup();
    send_command(CMD_GET, 16'd2, clock_ms, '0, '0, '0, '0, 5'd0);
    send_command(CMD_REMOVE, 16'd2, clock_ms, '0, '0, '0, '0, 5'd0);
    send_command(CMD_REMOVE, 16'd2, clock_ms, '0, '0, '0, '0, 5'd0);
    clock_ms += 32'd6000;
    send_command(CMD_GET, 16'd3, clock_ms, '0, '0, '0, '0, 5'd0);
    send_command(CMD_CLEAR, 16'd0, clock_ms, '0, '0, '0, '0, 5'd0);
  endtask

  task automatic test_limit_extremes();
    write_limit('0);
    send_command(CMD_PUT, 16'd9, clock_ms, $urandom, $urandom, $urandom, $urandom, 5'd0);
    send_command(CMD_GET, 16'd9, clock_ms, '0, '0, '0, '0, 5'd0);
    send_command(CMD_GET, 16'd9, clock_ms + 1, '0, '0, '0, '0, 5'd0);
    write_limit('1);
    send_command(CMD_PUT, 16'd9, clock_ms, $urandom, $urandom, $urandom, $urandom, 5'd0);
    send_command(CMD_GET, 16'd9, clock_ms + 32'h7FFF_FFFF, '0, '0, '0, '0, 5'd0);
    send_command(CMD_GET, 16'd9, clock_ms + 32'h8000_0000, '0, '0, '0, '0, 5'd0);
    clock_ms += 32'h8000_0000;
  endtask

  task automatic test_backpressure();
    bit saved;
    saved = idle_en;
    idle_en = 1'b0;
    hold_off = 1'b1;
    run_random(24);
    idle_en = saved;
    wait_idle();
  endtask

  // receiver side: random stall bursts, or one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_off = 1'b0;
        m_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_data_t     o;
    table_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      o = m_tdata;
      if (pending_results.size() == 0) begin
        flag_error("result transfer with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("ok", m_tuser, want.ok);
        check_field("slot_index", o.slot_index, want.slot);
        check_field("evicted_id", o.evicted_id, want.evicted);
        check_field("entry_id", o.entry_id, want.entry);
        check_field("out_x", o.out_x, want.x);
        check_field("out_y", o.out_y, want.y);
        check_field("out_z", o.out_z, want.z);
        check_field("out_range", o.out_range, want.rng);
        check_field("last", m_tlast, want.is_last);
        check_field("pad", o.pad, '0);
      end
      n_results++;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    clock_ms = 32'hFFFF_F000;
    test_rejects();
    test_fill_and_evict();
    test_lookup();
    test_limit_extremes();
    write_limit(LIMIT_RESET);
    run_random(20);
    test_backpressure();
    write_limit(31'd100);
    run_random(20);
    write_limit(31'd0);
    run_random(15);
    write_limit(31'h7FFF_FFFF);
    run_random(20);
    write_limit(31'($urandom_range(1, 20000)));
    idle_en = 1'b0;
    run_random(20);
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) flag_error("expected results never arrived");
    $display("Covered %0d put, %0d get, %0d remove, %0d clear, %0d snapshot, %0d unused-op",
             n_items[CMD_PUT], n_items[CMD_GET], n_items[CMD_REMOVE], n_items[CMD_CLEAR],
             n_items[CMD_SNAP], n_items[5] + n_items[6] + n_items[7]);
    $display("%0d results, %0d evictions, %0d multi-entry snapshots, 5 stale limits",
             n_results, n_evictions, n_multi_snaps);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
